### rtl/nec_ir_pkg.sv
// Shared types, codes and reset values for the NEC infrared edge interval decoder.
// No dependencies; every other file of the block imports this package.
`timescale 1ns / 1ps
`default_nettype none

package nec_ir_pkg;

   localparam int unsigned US_W   = 16;
   localparam int unsigned CMD_W  = 8;
   localparam int unsigned FRAME_W = 32;
   localparam int unsigned BITS_W = 6;
   localparam int unsigned CSR_IDX_W = 3;

   // An overflowed interval timer counts as this long a gap.
   localparam logic [US_W-1:0] OVERFLOW_INTERVAL_US = 16'd30000;

   localparam logic [US_W-1:0] RST_DEVICE_ADDRESS = 16'd0;
   localparam logic [US_W-1:0] RST_NOISE_FLOOR_US = 16'd400;
   localparam logic [US_W-1:0] RST_SYNC_GAP_US    = 16'd25000;
   localparam logic [US_W-1:0] RST_LEADER_MIN_US  = 16'd6000;
   localparam logic [US_W-1:0] RST_LEADER_MAX_US  = 16'd22000;
   localparam logic [US_W-1:0] RST_ONE_MIN_US     = 16'd1500;
   localparam logic [US_W-1:0] RST_BIT_MAX_US     = 16'd3500;
   localparam logic [US_W-1:0] RST_RECOVER_GAP_US = 16'd8000;

   localparam logic [BITS_W-1:0] FRAME_BITS     = 6'd32;
   localparam logic [CMD_W-1:0]  CMD_INVERSE_OK = 8'hFF;

   // Decoder phases.
   localparam logic [1:0] PH_IDLE   = 2'd0;
   localparam logic [1:0] PH_LEADER = 2'd1;
   localparam logic [1:0] PH_DATA   = 2'd2;
   localparam logic [1:0] PH_ERROR  = 2'd3;

   // Error codes.
   localparam logic [1:0] ERR_NONE       = 2'd0;
   localparam logic [1:0] ERR_BAD_LEADER = 2'd1;
   localparam logic [1:0] ERR_BAD_BIT    = 2'd2;
   localparam logic [1:0] ERR_MISMATCH   = 2'd3;

   // Register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_DEVICE_ADDRESS = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_NOISE_FLOOR_US = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SYNC_GAP_US    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_LEADER_MIN_US  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_LEADER_MAX_US  = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_ONE_MIN_US     = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_BIT_MAX_US     = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_RECOVER_GAP_US = 3'd7;

   typedef struct packed {
      logic [US_W-1:0] device_address;
      logic [US_W-1:0] noise_floor_us;
      logic [US_W-1:0] sync_gap_us;
      logic [US_W-1:0] leader_min_us;
      logic [US_W-1:0] leader_max_us;
      logic [US_W-1:0] one_min_us;
      logic [US_W-1:0] bit_max_us;
      logic [US_W-1:0] recover_gap_us;
   } cfg_type;

   typedef struct packed {
      logic [1:0]         phase;
      logic [FRAME_W-1:0] frame;
      logic [BITS_W-1:0]  bits;
   } state_type;

   typedef struct packed {
      logic             accepted;
      logic             leader_seen;
      logic             cmd_valid;
      logic [CMD_W-1:0] command;
      logic [1:0]       error_code;
      logic [US_W-1:0]  error_value;
      logic [1:0]       phase;
   } result_type;

endpackage

`default_nettype wire

### rtl/nec_ir_csr.sv
// Configuration registers of the NEC infrared decoder, written through a plain write port.
// Depends on nec_ir_pkg for the register indexes, reset values and cfg_type.
`timescale 1ns / 1ps
`default_nettype none

module nec_ir_csr
   import nec_ir_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 csr_write_en,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [US_W-1:0]      csr_wdata,
   output cfg_type                   cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_en) begin
         unique case (csr_index)
            CSR_DEVICE_ADDRESS: cfg_in.device_address = csr_wdata;
            CSR_NOISE_FLOOR_US: cfg_in.noise_floor_us = csr_wdata;
            CSR_SYNC_GAP_US:    cfg_in.sync_gap_us    = csr_wdata;
            CSR_LEADER_MIN_US:  cfg_in.leader_min_us  = csr_wdata;
            CSR_LEADER_MAX_US:  cfg_in.leader_max_us  = csr_wdata;
            CSR_ONE_MIN_US:     cfg_in.one_min_us     = csr_wdata;
            CSR_BIT_MAX_US:     cfg_in.bit_max_us     = csr_wdata;
            CSR_RECOVER_GAP_US: cfg_in.recover_gap_us = csr_wdata;
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.device_address <= RST_DEVICE_ADDRESS;
         cfg_ff.noise_floor_us <= RST_NOISE_FLOOR_US;
         cfg_ff.sync_gap_us    <= RST_SYNC_GAP_US;
         cfg_ff.leader_min_us  <= RST_LEADER_MIN_US;
         cfg_ff.leader_max_us  <= RST_LEADER_MAX_US;
         cfg_ff.one_min_us     <= RST_ONE_MIN_US;
         cfg_ff.bit_max_us     <= RST_BIT_MAX_US;
         cfg_ff.recover_gap_us <= RST_RECOVER_GAP_US;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

### rtl/nec_ir_step.sv
// Combinational decode of one edge interval: next decoder state and the result item.
// Depends on nec_ir_pkg for the phase and error codes and the shared structs.
`timescale 1ns / 1ps
`default_nettype none

module nec_ir_step
   import nec_ir_pkg::*;
(
   input  wire cfg_type          cfg,
   input  wire state_type        cur,
   input  wire logic [US_W-1:0]  interval_us,
   input  wire logic             overflowed,
   output state_type             nxt,
   output result_type            res
);

   logic [US_W-1:0]    t;
   logic               below_one;
   logic               is_bit;
   logic [FRAME_W-1:0] shifted;
   logic [BITS_W-1:0]  bits_inc;
   logic               frame_ok;

   always_comb begin
      t         = overflowed ? OVERFLOW_INTERVAL_US : interval_us;
      // Threshold order matters when the settings overlap: zero bit first.
      below_one = (t < cfg.one_min_us);
      is_bit    = below_one || (t < cfg.bit_max_us);
      shifted   = {~below_one, cur.frame[FRAME_W-1:1]};
      bits_inc  = cur.bits + 1'b1;
      frame_ok  = (shifted[15:0] == cfg.device_address)
               && ((shifted[23:16] ^ shifted[31:24]) == CMD_INVERSE_OK);

      nxt = cur;
      res = '0;

      if (t >= cfg.noise_floor_us) begin
         res.accepted = 1'b1;
         if (t > cfg.sync_gap_us) begin
            nxt.phase = PH_LEADER;
         end else begin
            unique case (cur.phase)
               PH_IDLE: begin
                  nxt.phase = PH_LEADER;
               end
               PH_LEADER: begin
                  if (t > cfg.leader_min_us && t < cfg.leader_max_us) begin
                     nxt.frame       = '0;
                     nxt.bits        = '0;
                     nxt.phase       = PH_DATA;
                     res.leader_seen = 1'b1;
                  end else begin
                     res.error_code  = ERR_BAD_LEADER;
                     res.error_value = t;
                     nxt.phase       = PH_ERROR;
                  end
               end
               PH_DATA: begin
                  if (!is_bit) begin
                     res.error_code  = ERR_BAD_BIT;
                     res.error_value = t;
                     nxt.phase       = PH_ERROR;
                  end else begin
                     nxt.frame = shifted;
                     nxt.bits  = bits_inc;
                     if (bits_inc >= FRAME_BITS) begin
                        if (frame_ok) begin
                           res.cmd_valid = 1'b1;
                           res.command   = shifted[23:16];
                           nxt.phase     = PH_IDLE;
                        end else begin
                           res.error_code  = ERR_MISMATCH;
                           res.error_value = shifted[15:0];
                           nxt.phase       = PH_ERROR;
                        end
                     end
                  end
               end
               PH_ERROR: begin
                  if (t >= cfg.recover_gap_us) begin
                     nxt.phase = PH_LEADER;
                  end
               end
               default: begin
                  nxt = cur;
               end
            endcase
         end
      end

      res.phase = nxt.phase;
   end

endmodule

`default_nettype wire

### rtl/nec_ir_edge_interval_decoder.sv
// Top level of the NEC infrared edge interval decoder: input register, decode, result register.
// Depends on nec_ir_pkg, nec_ir_csr and nec_ir_step.
//
//   channel   direction  handshake              payload
//   req       in         req_valid/req_ready    req_interval_us, req_overflowed
//   rsp       out        rsp_valid/rsp_ready    rsp_accepted .. rsp_phase
//   csr       in         csr_write_en           csr_index, csr_wdata
//
// One edge per cycle unless rsp stalls; an edge moves from the input to the result register.
// The decode of an edge happens when it leaves the input register, updating the state in that cycle.
// A stalled result holds in the output register while one more edge waits in the input register.
// Synchronous reset puts the decoder in idle with an empty frame and default thresholds.
`timescale 1ns / 1ps
`default_nettype none

module nec_ir_edge_interval_decoder
   import nec_ir_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,

   input  wire logic                 req_valid,
   output logic                      req_ready,
   input  wire logic [US_W-1:0]      req_interval_us,
   input  wire logic                 req_overflowed,

   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   output logic                      rsp_accepted,
   output logic                      rsp_leader_seen,
   output logic                      rsp_cmd_valid,
   output logic [CMD_W-1:0]          rsp_command,
   output logic [1:0]                rsp_error_code,
   output logic [US_W-1:0]           rsp_error_value,
   output logic [1:0]                rsp_phase,

   input  wire logic                 csr_write_en,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [US_W-1:0]      csr_wdata
);

   cfg_type    cfg;
   state_type  state_ff;
   state_type  state_in;
   result_type step_res;
   result_type result_ff;

   logic            in_valid_ff;
   logic [US_W-1:0] in_interval_ff;
   logic            in_overflowed_ff;
   logic            out_valid_ff;
   logic            advance;

   nec_ir_csr u_csr (
      .clock        (clock),
      .reset        (reset),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .cfg          (cfg)
   );

   nec_ir_step u_step (
      .cfg         (cfg),
      .cur         (state_ff),
      .interval_us (in_interval_ff),
      .overflowed  (in_overflowed_ff),
      .nxt         (state_in),
      .res         (step_res)
   );

   // An edge is decoded when it moves from the input register into a free result register.
   assign advance   = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff    <= 1'b0;
         out_valid_ff   <= 1'b0;
         state_ff.phase <= PH_IDLE;
         state_ff.frame <= '0;
         state_ff.bits  <= '0;
      end else begin
         if (req_ready) begin
            in_valid_ff <= req_valid;
         end
         if (advance) begin
            out_valid_ff <= 1'b1;
            state_ff     <= state_in;
         end else if (rsp_ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_interval_ff   <= req_interval_us;
         in_overflowed_ff <= req_overflowed;
      end
      if (advance) begin
         result_ff <= step_res;
      end
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_accepted    = result_ff.accepted;
   assign rsp_leader_seen = result_ff.leader_seen;
   assign rsp_cmd_valid   = result_ff.cmd_valid;
   assign rsp_command     = result_ff.command;
   assign rsp_error_code  = result_ff.error_code;
   assign rsp_error_value = result_ff.error_value;
   assign rsp_phase       = result_ff.phase;

`ifndef ASSERT_OFF
   // The bit count never reaches a full frame while still collecting data.
   a_data_bits_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff.phase == PH_DATA) |-> (state_ff.bits < FRAME_BITS))
      else $error("data phase with a full bit count");

   // A good frame carries no error and returns the decoder to idle.
   a_cmd_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_cmd_valid) |->
         (rsp_error_code == ERR_NONE && rsp_phase == PH_IDLE && rsp_accepted))
      else $error("command transfer with error or wrong phase");

   // A leader opens the data phase with an empty frame.
   a_leader_opens_frame: assert property (@(posedge clock) disable iff (reset)
      (advance && step_res.leader_seen) |=>
         (state_ff.phase == PH_DATA && state_ff.bits == '0))
      else $error("leader did not open a frame");

   // A result held by a stall keeps the decoder state frozen.
   a_stall_holds_state: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> $stable(state_ff))
      else $error("decoder state moved during a result stall");
`endif

endmodule

`default_nettype wire

### sim/tb.sv
// Self-checking testbench for nec_ir_edge_interval_decoder: directed and random edge intervals.
// Depends on nec_ir_pkg and the decoder RTL; a built-in decoder model predicts each result.
`timescale 1ns / 1ps

module tb;
   import nec_ir_pkg::*;

   typedef struct packed {
      logic [US_W-1:0] interval_us;
      logic            overflowed;
   } gap_stim_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   logic [US_W-1:0]      req_interval_us = '0;
   logic                 req_overflowed = 1'b0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   logic                 rsp_accepted;
   logic                 rsp_leader_seen;
   logic                 rsp_cmd_valid;
   logic [CMD_W-1:0]     rsp_command;
   logic [1:0]           rsp_error_code;
   logic [US_W-1:0]      rsp_error_value;
   logic [1:0]           rsp_phase;
   logic                 csr_write_en = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [US_W-1:0]      csr_wdata = '0;

   // Decoder model state and its copy of the thresholds.
   cfg_type              thr;
   logic [1:0]           dec_phase;
   logic [FRAME_W-1:0]   frame_sr;
   logic [BITS_W-1:0]    bit_count;

   gap_stim_type pending_gaps[$];
   result_type   expected_results[$];
   int n_queued = 0;
   int n_checked = 0;
   int live_items = 0;
   int mismatches = 0;
   int tx_count = 0;
   int rx_count = 0;
   int hold_left = 0;

   nec_ir_edge_interval_decoder u_top (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_interval_us(req_interval_us),
      .req_overflowed (req_overflowed),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_accepted   (rsp_accepted),
      .rsp_leader_seen(rsp_leader_seen),
      .rsp_cmd_valid  (rsp_cmd_valid),
      .rsp_command    (rsp_command),
      .rsp_error_code (rsp_error_code),
      .rsp_error_value(rsp_error_value),
      .rsp_phase      (rsp_phase),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata)
   );

   always #5 clock = ~clock;

   function automatic result_type decode_edge(input logic [US_W-1:0] iv, input logic ovf);
      result_type r;
      logic [US_W-1:0] t;
      r = '0;
      t = ovf ? OVERFLOW_INTERVAL_US : iv;
      if (t >= thr.noise_floor_us) begin
         r.accepted = 1'b1;
         if (t > thr.sync_gap_us) begin
            dec_phase = PH_LEADER;
         end else begin
            case (dec_phase)
               PH_IDLE: begin
                  dec_phase = PH_LEADER;
               end
               PH_LEADER: begin
                  if (t > thr.leader_min_us && t < thr.leader_max_us) begin
                     frame_sr = '0;
                     bit_count = '0;
                     dec_phase = PH_DATA;
                     r.leader_seen = 1'b1;
                  end else begin
                     r.error_code = ERR_BAD_LEADER;
                     r.error_value = t;
                     dec_phase = PH_ERROR;
                  end
               end
               PH_DATA: begin
                  // A zero bit wins over a one bit when the thresholds are out of order.
                  if (t < thr.one_min_us || t < thr.bit_max_us) begin
                     frame_sr = {t >= thr.one_min_us, frame_sr[FRAME_W-1:1]};
                     bit_count = bit_count + 1'b1;
                     if (bit_count >= FRAME_BITS) begin
                        if (frame_sr[15:0] == thr.device_address &&
                            (frame_sr[23:16] ^ frame_sr[31:24]) == CMD_INVERSE_OK) begin
                           r.cmd_valid = 1'b1;
                           r.command = frame_sr[23:16];
                           dec_phase = PH_IDLE;
                        end else begin
                           r.error_code = ERR_MISMATCH;
                           r.error_value = frame_sr[15:0];
                           dec_phase = PH_ERROR;
                        end
                     end
                  end else begin
                     r.error_code = ERR_BAD_BIT;
                     r.error_value = t;
                     dec_phase = PH_ERROR;
                  end
               end
               default: begin
                  if (t >= thr.recover_gap_us) dec_phase = PH_LEADER;
               end
            endcase
         end
      end
      r.phase = dec_phase;
      return r;
   endfunction

   function automatic void check_field(input string name, input logic [31:0] want,
                                       input logic [31:0] got);
      if (want !== got) begin
         mismatches++;
         if (mismatches <= 10)
            $display("Mismatch on %s: expected %0d, got %0d (result %0d)",
                     name, want, got, n_checked);
      end
   endfunction

   // Sender: one interval offered at a time, held until its transfer.
   always @(posedge clock) begin : drive_req
      gap_stim_type nxt;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            expected_results.push_back(decode_edge(req_interval_us, req_overflowed));
            tx_count++;
         end
         if (!req_valid || req_ready) begin
            if (pending_gaps.size() > 0 &&
                ((tx_count >= 400 && tx_count < 560) || $urandom_range(99) >= 36)) begin
               nxt = pending_gaps.pop_front();
               req_valid <= 1'b1;
               req_interval_us <= nxt.interval_us;
               req_overflowed <= nxt.overflowed;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Receiver: random stalls, a steady window, and a long hold-off every 300 transfers.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            rx_count++;
            if (rx_count % 300 == 0) hold_left = 80;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else if (rx_count >= 400 && rx_count < 560) begin
            rsp_ready <= 1'b1;
         end else begin
            rsp_ready <= ($urandom_range(99) >= 36);
         end
      end
   end

   always @(posedge clock) begin : check_rsp
      result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_results.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("Result %0d arrived with none expected", n_checked);
         end else begin
            want = expected_results.pop_front();
            check_field("accepted", want.accepted, rsp_accepted);
            check_field("leader_seen", want.leader_seen, rsp_leader_seen);
            check_field("cmd_valid", want.cmd_valid, rsp_cmd_valid);
            check_field("command", want.command, rsp_command);
            check_field("error_code", want.error_code, rsp_error_code);
            check_field("error_value", want.error_value, rsp_error_value);
            check_field("phase", want.phase, rsp_phase);
         end
         n_checked++;
      end
   end

   task automatic push_gap(input int iv, input bit ovf);
      gap_stim_type s;
      s.interval_us = iv[US_W-1:0];
      s.overflowed = ovf;
      pending_gaps.push_back(s);
      n_queued++;
      if ((ovf ? OVERFLOW_INTERVAL_US : s.interval_us) >= thr.noise_floor_us) live_items++;
   endtask

   function automatic int in_range(input int lo, input int hi);
      if (lo > hi || lo < 0 || hi > 65535) return $urandom_range(65535, 0);
      // Land on the range ends now and then so boundaries get exercised.
      case ($urandom_range(7))
         0: return lo;
         1: return hi;
         default: return $urandom_range(hi, lo);
      endcase
   endfunction

   function automatic int int_max(input int a, input int b);
      return (a > b) ? a : b;
   endfunction

   function automatic int int_min(input int a, input int b);
      return (a < b) ? a : b;
   endfunction

   function automatic int random_interval();
      logic [US_W-1:0] mark;
      case ($urandom_range(6))
         0: mark = thr.noise_floor_us;
         1: mark = thr.sync_gap_us;
         2: mark = thr.leader_min_us;
         3: mark = thr.leader_max_us;
         4: mark = thr.one_min_us;
         5: mark = thr.bit_max_us;
         default: mark = thr.recover_gap_us;
      endcase
      case ($urandom_range(3))
         0: return $urandom_range(65535, 0);
         1: return int'(mark) + $urandom_range(2, 0) - 1;
         2: return $urandom_range(1) ? 65535 : 0;
         default: return in_range(thr.noise_floor_us, thr.bit_max_us);
      endcase
   endfunction

   // A resync gap, a leader and data bits; bits_kept below 32 breaks the frame off.
   task automatic queue_frame(input int bits_kept);
      logic [FRAME_W-1:0] word;
      int nf, sg;
      nf = thr.noise_floor_us;
      sg = thr.sync_gap_us;
      word[15:0] = ($urandom_range(3) != 0) ? thr.device_address : 16'($urandom);
      word[23:16] = 8'($urandom);
      word[31:24] = ($urandom_range(3) != 0) ? ~word[23:16] : 8'($urandom);
      if ($urandom_range(1)) push_gap($urandom_range(65535, 0), 1'b1);
      else push_gap(in_range(sg + 1, 65535), 1'b0);
      push_gap(in_range(int_max(thr.leader_min_us + 1, nf),
                        int_min(thr.leader_max_us - 1, sg)), 1'b0);
      for (int b = 0; b < bits_kept && b < FRAME_W; b++) begin
         if (nf > 0 && $urandom_range(9) == 0) push_gap(in_range(0, nf - 1), 1'b0);
         if (word[b])
            push_gap(in_range(int_max(thr.one_min_us, nf),
                              int_min(thr.bit_max_us - 1, sg)), 1'b0);
         else
            push_gap(in_range(nf, int_min(thr.one_min_us - 1, sg)), 1'b0);
      end
      if (bits_kept < FRAME_W) push_gap(random_interval(), $urandom_range(7) == 0);
   endtask

   task automatic wait_idle();
      while (n_checked < n_queued) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [US_W-1:0] val);
      @(posedge clock);
      csr_write_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
   endtask

   task automatic program_regs(input cfg_type c);
      write_reg(CSR_DEVICE_ADDRESS, c.device_address);
      write_reg(CSR_NOISE_FLOOR_US, c.noise_floor_us);
      write_reg(CSR_SYNC_GAP_US, c.sync_gap_us);
      write_reg(CSR_LEADER_MIN_US, c.leader_min_us);
      write_reg(CSR_LEADER_MAX_US, c.leader_max_us);
      write_reg(CSR_ONE_MIN_US, c.one_min_us);
      write_reg(CSR_BIT_MAX_US, c.bit_max_us);
      write_reg(CSR_RECOVER_GAP_US, c.recover_gap_us);
      @(posedge clock);
      csr_write_en <= 1'b0;
      thr = c;
   endtask

   // Thresholds in their usual order with random spacing.
   function automatic cfg_type ordered_cfg(input logic [US_W-1:0] addr);
      cfg_type c;
      int nf, om, bm, lmn, lmx;
      nf = $urandom_range(600, 50);
      om = nf + $urandom_range(1500, 300);
      bm = om + $urandom_range(2500, 300);
      lmn = bm + $urandom_range(3000, 100);
      lmx = lmn + $urandom_range(9000, 2);
      c.device_address = addr;
      c.noise_floor_us = 16'(nf);
      c.sync_gap_us = 16'(lmx + $urandom_range(10000, 0));
      c.leader_min_us = 16'(lmn);
      c.leader_max_us = 16'(lmx);
      c.one_min_us = 16'(om);
      c.bit_max_us = 16'(bm);
      c.recover_gap_us = 16'($urandom_range(lmx, bm));
      return c;
   endfunction

   task automatic run_random(input int target);
      int live0, queued0, r;
      live0 = live_items;
      queued0 = n_queued;
      while (live_items - live0 < target && n_queued - queued0 < 4 * target) begin
         r = $urandom_range(99);
         if (r < 65) queue_frame(FRAME_W);
         else if (r < 85) queue_frame($urandom_range(FRAME_W - 1, 0));
         else repeat ($urandom_range(5, 1)) push_gap(random_interval(), $urandom_range(9) == 0);
      end
      wait_idle();
   endtask

   initial begin
      thr = {RST_DEVICE_ADDRESS, RST_NOISE_FLOOR_US, RST_SYNC_GAP_US, RST_LEADER_MIN_US,
             RST_LEADER_MAX_US, RST_ONE_MIN_US, RST_BIT_MAX_US, RST_RECOVER_GAP_US};
      dec_phase = PH_IDLE;
      frame_sr = '0;
      bit_count = '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Directed walk through the decoder with the reset thresholds.
      push_gap(0, 1'b0);         // noise while idle
      push_gap(399, 1'b0);       // just under the noise floor
      push_gap(400, 1'b0);       // idle moves to leader wait
      push_gap(6000, 1'b0);      // leader must be strictly above its minimum
      push_gap(7999, 1'b0);      // stays in error wait
      push_gap(8000, 1'b0);      // recovers to leader wait
      push_gap(22000, 1'b0);     // leader must be strictly below its maximum
      push_gap(65535, 1'b0);     // sync gap
      push_gap(6001, 1'b0);      // good leader
      push_gap(399, 1'b0);       // noise inside a frame
      push_gap(3500, 1'b0);      // bit too long
      push_gap(0, 1'b1);         // overflow counts as a sync gap
      push_gap(21999, 1'b0);
      push_gap(1499, 1'b0);
      push_gap(1500, 1'b0);
      push_gap(3499, 1'b0);
      push_gap(25000, 1'b0);     // not a gap, but a bad bit
      push_gap(25001, 1'b0);
      push_gap(65535, 1'b1);
      push_gap(25000, 1'b0);     // bad leader
      run_random(100);

      repeat (3) begin
         program_regs(ordered_cfg(16'($urandom)));
         run_random(100);
      end
      program_regs('0);
      run_random(40);
      program_regs('1);
      run_random(40);
      // Sync gap at the overflow interval: an overflow is judged as an ordinary interval.
      program_regs({16'h5A3C, 16'd400, 16'd30000, 16'd6000, 16'd40000, 16'd1500,
                    16'd3500, 16'd8000});
      run_random(60);
      // Noise floor above the overflow interval: an overflow is ignored.
      program_regs({16'h00FF, 16'd30001, 16'd65535, 16'd30002, 16'd60000, 16'd40000,
                    16'd50000, 16'd45000});
      run_random(60);
      // One-bit threshold above the bit maximum.
      program_regs({16'hFFFF, 16'd400, 16'd25000, 16'd6000, 16'd22000, 16'd3000,
                    16'd1500, 16'd8000});
      run_random(80);
      program_regs(ordered_cfg(16'hFFFF));
      run_random(150);

      repeat (8) @(posedge clock);
      if (mismatches == 0 && expected_results.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

   initial begin
      #3_000_000;
      $display("Verification failed");
      $finish;
   end

endmodule
